@@ hw/rtl/cubic_bezier_point_and_tangent_assert.svh @@
// Assertion macros for the cubic Bezier point and tangent evaluator.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef CUBIC_BEZIER_POINT_AND_TANGENT_ASSERT_SVH
`define CUBIC_BEZIER_POINT_AND_TANGENT_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks that cons holds in the same cycle whenever ante holds.
`define BCZ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define BCZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BCZ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BCZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/bcz_pkg.sv @@
// Shared constants, types and codes for the cubic Bezier evaluator.
// Used by every RTL module of the block; depends on nothing else.
package bcz_pkg;

  // Field formats.
  localparam int COORD_WIDTH = 32;
  localparam int T_FRAC_BITS = 16;
  localparam int T_WIDTH     = T_FRAC_BITS + 1;

  // Control points and register file.
  localparam int NUM_CTRL  = 4;
  localparam int NUM_REGS  = 2 * NUM_CTRL;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  // Internal widths. Weights carry 3*T_FRAC_BITS fraction bits for both commands.
  localparam int SQ_WIDTH   = 2 * T_FRAC_BITS + 1;
  localparam int CUBE_WIDTH = 3 * T_FRAC_BITS + 1;
  localparam int W_WIDTH    = 3 * T_FRAC_BITS + 3;
  localparam int W_LO       = W_WIDTH / 2;
  localparam int W_HI       = W_WIDTH - W_LO;
  localparam int PLO_WIDTH  = COORD_WIDTH + W_LO + 1;
  localparam int PHI_WIDTH  = COORD_WIDTH + W_HI;
  localparam int PROD_WIDTH = COORD_WIDTH + W_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 2;
  localparam int RND_SHIFT  = 3 * T_FRAC_BITS;

  // Pipeline depth.
  localparam int NUM_STAGES = 7;

  localparam logic [T_WIDTH-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  localparam logic signed [ACC_WIDTH-1:0] RND_HALF =
    {{(ACC_WIDTH - RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT - 1){1'b0}}};

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [T_WIDTH-1:0]     tval_t;
  typedef logic signed [W_WIDTH-1:0]     weight_t;
  typedef logic signed [ACC_WIDTH-1:0]   acc_t;
  typedef logic        [NUM_STAGES-1:0]  stage_vec_t;

  typedef weight_t [NUM_CTRL-1:0] weight_vec_t;
  typedef coord_t  [NUM_CTRL-1:0] coord_vec_t;

  // Command selector.
  typedef enum logic {
    CMD_POINT   = 1'b0,
    CMD_TANGENT = 1'b1
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P0_X = CFG_IDX_W'(0),
    REG_P0_Y = CFG_IDX_W'(1),
    REG_P1_X = CFG_IDX_W'(2),
    REG_P1_Y = CFG_IDX_W'(3),
    REG_P2_X = CFG_IDX_W'(4),
    REG_P2_Y = CFG_IDX_W'(5),
    REG_P3_X = CFG_IDX_W'(6),
    REG_P3_Y = CFG_IDX_W'(7)
  } reg_idx_t;

  // Input transaction.
  typedef struct packed {
    cmd_t  cmd;
    tval_t param_t;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   overflow;
  } out_item_t;

  // Two partial sums of one coordinate; the rounding half is already in sum_a.
  typedef struct packed {
    acc_t sum_a;
    acc_t sum_b;
  } pair_sum_t;

endpackage

@@ hw/rtl/bcz_weights.sv @@
// Weight generator: clamps t and forms the four basis weights over three stages.
// Depends on bcz_pkg.
module bcz_weights (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  bcz_pkg::in_item_t    in_item,
  output bcz_pkg::weight_vec_t w_out
);

  // Stage 0: clamp t to one and form s = 1 - t.
  bcz_pkg::tval_t t_clamp;
  bcz_pkg::cmd_t  cmd0_r;
  bcz_pkg::tval_t t0_r;
  bcz_pkg::tval_t s0_r;

  assign t_clamp = (in_item.param_t > bcz_pkg::T_ONE) ? bcz_pkg::T_ONE : in_item.param_t;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cmd0_r <= in_item.cmd;
      t0_r   <= t_clamp;
      s0_r   <= bcz_pkg::T_ONE - t_clamp;
    end
  end

  // Stage 1: the three second-degree products.
  logic [2*bcz_pkg::T_WIDTH-1:0] ss_full;
  logic [2*bcz_pkg::T_WIDTH-1:0] st_full;
  logic [2*bcz_pkg::T_WIDTH-1:0] tt_full;
  logic [bcz_pkg::SQ_WIDTH-1:0]  ss1_r;
  logic [bcz_pkg::SQ_WIDTH-1:0]  st1_r;
  logic [bcz_pkg::SQ_WIDTH-1:0]  tt1_r;
  bcz_pkg::tval_t                t1_r;
  bcz_pkg::tval_t                s1_r;
  bcz_pkg::cmd_t                 cmd1_r;

  assign ss_full = {{bcz_pkg::T_WIDTH{1'b0}}, s0_r} * {{bcz_pkg::T_WIDTH{1'b0}}, s0_r};
  assign st_full = {{bcz_pkg::T_WIDTH{1'b0}}, s0_r} * {{bcz_pkg::T_WIDTH{1'b0}}, t0_r};
  assign tt_full = {{bcz_pkg::T_WIDTH{1'b0}}, t0_r} * {{bcz_pkg::T_WIDTH{1'b0}}, t0_r};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ss1_r  <= ss_full[bcz_pkg::SQ_WIDTH-1:0];
      st1_r  <= st_full[bcz_pkg::SQ_WIDTH-1:0];
      tt1_r  <= tt_full[bcz_pkg::SQ_WIDTH-1:0];
      t1_r   <= t0_r;
      s1_r   <= s0_r;
      cmd1_r <= cmd0_r;
    end
  end

  // Stage 2: cubic Bernstein weights for a point, derivative weights for a tangent.
  localparam int CUBE_FULL = bcz_pkg::SQ_WIDTH + bcz_pkg::T_WIDTH;
  localparam int CUBE_PAD  = bcz_pkg::W_WIDTH - bcz_pkg::CUBE_WIDTH;
  localparam int SQ_PAD    = bcz_pkg::W_WIDTH - bcz_pkg::SQ_WIDTH;

  logic [CUBE_FULL-1:0] sss_full;
  logic [CUBE_FULL-1:0] sst_full;
  logic [CUBE_FULL-1:0] stt_full;
  logic [CUBE_FULL-1:0] ttt_full;
  bcz_pkg::weight_t     sss_w;
  bcz_pkg::weight_t     sst_w;
  bcz_pkg::weight_t     stt_w;
  bcz_pkg::weight_t     ttt_w;
  bcz_pkg::weight_t     ss_w;
  bcz_pkg::weight_t     st_w;
  bcz_pkg::weight_t     tt_w;
  bcz_pkg::weight_t     ss3;
  bcz_pkg::weight_t     st6;
  bcz_pkg::weight_t     tt3;
  bcz_pkg::weight_vec_t w_nxt;
  bcz_pkg::weight_vec_t w2_r;

  assign sss_full = {{bcz_pkg::T_WIDTH{1'b0}}, ss1_r} * {{bcz_pkg::SQ_WIDTH{1'b0}}, s1_r};
  assign sst_full = {{bcz_pkg::T_WIDTH{1'b0}}, ss1_r} * {{bcz_pkg::SQ_WIDTH{1'b0}}, t1_r};
  assign stt_full = {{bcz_pkg::T_WIDTH{1'b0}}, tt1_r} * {{bcz_pkg::SQ_WIDTH{1'b0}}, s1_r};
  assign ttt_full = {{bcz_pkg::T_WIDTH{1'b0}}, tt1_r} * {{bcz_pkg::SQ_WIDTH{1'b0}}, t1_r};

  assign sss_w = {{CUBE_PAD{1'b0}}, sss_full[bcz_pkg::CUBE_WIDTH-1:0]};
  assign sst_w = {{CUBE_PAD{1'b0}}, sst_full[bcz_pkg::CUBE_WIDTH-1:0]};
  assign stt_w = {{CUBE_PAD{1'b0}}, stt_full[bcz_pkg::CUBE_WIDTH-1:0]};
  assign ttt_w = {{CUBE_PAD{1'b0}}, ttt_full[bcz_pkg::CUBE_WIDTH-1:0]};

  assign ss_w = {{SQ_PAD{1'b0}}, ss1_r};
  assign st_w = {{SQ_PAD{1'b0}}, st1_r};
  assign tt_w = {{SQ_PAD{1'b0}}, tt1_r};

  assign ss3 = ss_w + (ss_w <<< 1);
  assign st6 = (st_w <<< 1) + (st_w <<< 2);
  assign tt3 = tt_w + (tt_w <<< 1);

  // The tangent weights are -3s^2, 3s^2 - 6st, 6st - 3t^2 and 3t^2, lifted by one
  // t fraction so both commands round at the same point.
  always_comb begin
    case (cmd1_r)
      bcz_pkg::CMD_TANGENT: begin
        w_nxt[0] = (-ss3) <<< bcz_pkg::T_FRAC_BITS;
        w_nxt[1] = (ss3 - st6) <<< bcz_pkg::T_FRAC_BITS;
        w_nxt[2] = (st6 - tt3) <<< bcz_pkg::T_FRAC_BITS;
        w_nxt[3] = tt3 <<< bcz_pkg::T_FRAC_BITS;
      end
      default: begin
        w_nxt[0] = sss_w;
        w_nxt[1] = sst_w + (sst_w <<< 1);
        w_nxt[2] = stt_w + (stt_w <<< 1);
        w_nxt[3] = ttt_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      w2_r <= w_nxt;
    end
  end

  assign w_out = w2_r;

endmodule

@@ hw/rtl/bcz_mac.sv @@
// Multiply-accumulate for one coordinate: split weight products, then pairwise sums.
// Depends on bcz_pkg.
module bcz_mac (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  bcz_pkg::weight_vec_t w_in,
  input  bcz_pkg::coord_vec_t  q_in,
  output bcz_pkg::pair_sum_t   sums
);

  localparam int PLO_PAD  = bcz_pkg::PLO_WIDTH - bcz_pkg::COORD_WIDTH;
  localparam int PHI_PAD  = bcz_pkg::PHI_WIDTH - bcz_pkg::COORD_WIDTH;
  localparam int LO_PAD   = bcz_pkg::PLO_WIDTH - bcz_pkg::W_LO;
  localparam int HI_PAD   = bcz_pkg::PHI_WIDTH - bcz_pkg::W_HI;
  localparam int PHI_EXT  = bcz_pkg::PROD_WIDTH - bcz_pkg::PHI_WIDTH;
  localparam int PLO_EXT  = bcz_pkg::PROD_WIDTH - bcz_pkg::PLO_WIDTH;
  localparam int PROD_EXT = bcz_pkg::ACC_WIDTH - bcz_pkg::PROD_WIDTH;

  logic signed [bcz_pkg::PLO_WIDTH-1:0]  plo3_r  [bcz_pkg::NUM_CTRL];
  logic signed [bcz_pkg::PHI_WIDTH-1:0]  phi3_r  [bcz_pkg::NUM_CTRL];
  logic signed [bcz_pkg::PROD_WIDTH-1:0] prod4_r [bcz_pkg::NUM_CTRL];

  for (genvar i = 0; i < bcz_pkg::NUM_CTRL; i++) begin : g_term
    logic signed [bcz_pkg::PLO_WIDTH-1:0]  q_lo;
    logic signed [bcz_pkg::PLO_WIDTH-1:0]  w_lo;
    logic signed [bcz_pkg::PHI_WIDTH-1:0]  q_hi;
    logic signed [bcz_pkg::PHI_WIDTH-1:0]  w_hi;
    logic signed [bcz_pkg::PLO_WIDTH-1:0]  plo_nxt;
    logic signed [bcz_pkg::PHI_WIDTH-1:0]  phi_nxt;
    logic signed [bcz_pkg::PROD_WIDTH-1:0] phi_ext;
    logic signed [bcz_pkg::PROD_WIDTH-1:0] plo_ext;
    logic signed [bcz_pkg::PROD_WIDTH-1:0] prod_nxt;

    // Stage 3: the weight is split into an unsigned low half and a signed high half.
    assign q_lo = {{PLO_PAD{q_in[i][bcz_pkg::COORD_WIDTH-1]}}, q_in[i]};
    assign w_lo = {{LO_PAD{1'b0}}, w_in[i][bcz_pkg::W_LO-1:0]};
    assign q_hi = {{PHI_PAD{q_in[i][bcz_pkg::COORD_WIDTH-1]}}, q_in[i]};
    assign w_hi = {{HI_PAD{w_in[i][bcz_pkg::W_WIDTH-1]}},
                   w_in[i][bcz_pkg::W_WIDTH-1:bcz_pkg::W_LO]};

    assign plo_nxt = q_lo * w_lo;
    assign phi_nxt = q_hi * w_hi;

    always_ff @(posedge clk) begin
      if (en[0]) begin
        plo3_r[i] <= plo_nxt;
        phi3_r[i] <= phi_nxt;
      end
    end

    // Stage 4: recombine the two halves into the exact product.
    assign phi_ext  = {{PHI_EXT{phi3_r[i][bcz_pkg::PHI_WIDTH-1]}}, phi3_r[i]};
    assign plo_ext  = {{PLO_EXT{plo3_r[i][bcz_pkg::PLO_WIDTH-1]}}, plo3_r[i]};
    assign prod_nxt = (phi_ext <<< bcz_pkg::W_LO) + plo_ext;

    always_ff @(posedge clk) begin
      if (en[1]) begin
        prod4_r[i] <= prod_nxt;
      end
    end
  end

  // Stage 5: pairwise sums; the rounding half rides along with the first pair.
  bcz_pkg::acc_t prod_a0;
  bcz_pkg::acc_t prod_a1;
  bcz_pkg::acc_t prod_b0;
  bcz_pkg::acc_t prod_b1;
  bcz_pkg::pair_sum_t sums_nxt;
  bcz_pkg::pair_sum_t sums5_r;

  assign prod_a0 = {{PROD_EXT{prod4_r[0][bcz_pkg::PROD_WIDTH-1]}}, prod4_r[0]};
  assign prod_a1 = {{PROD_EXT{prod4_r[1][bcz_pkg::PROD_WIDTH-1]}}, prod4_r[1]};
  assign prod_b0 = {{PROD_EXT{prod4_r[2][bcz_pkg::PROD_WIDTH-1]}}, prod4_r[2]};
  assign prod_b1 = {{PROD_EXT{prod4_r[3][bcz_pkg::PROD_WIDTH-1]}}, prod4_r[3]};

  assign sums_nxt.sum_a = prod_a0 + prod_a1 + bcz_pkg::RND_HALF;
  assign sums_nxt.sum_b = prod_b0 + prod_b1;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sums5_r <= sums_nxt;
    end
  end

  assign sums = sums5_r;

endmodule

@@ hw/rtl/bcz_round.sv @@
// Output stage: final add, arithmetic shift to Q16.16 and saturation of both coordinates.
// Depends on bcz_pkg.
module bcz_round (
  input  logic               clk,
  input  logic               en,
  input  bcz_pkg::pair_sum_t sums_x,
  input  bcz_pkg::pair_sum_t sums_y,
  output bcz_pkg::out_item_t out_item
);

  localparam int RES_WIDTH = bcz_pkg::ACC_WIDTH - bcz_pkg::RND_SHIFT;
  localparam int TOP_WIDTH = RES_WIDTH - bcz_pkg::COORD_WIDTH + 1;

  typedef struct packed {
    bcz_pkg::coord_t value;
    logic            sat;
  } sat_res_t;

  // Adds the two partial sums, drops the fraction bits and clamps to the coordinate range.
  function automatic sat_res_t round_sat(input bcz_pkg::acc_t a, input bcz_pkg::acc_t b);
    bcz_pkg::acc_t          total;
    logic [RES_WIDTH-1:0]   res;
    logic [TOP_WIDTH-1:0]   top_bits;
    sat_res_t               r;
    total    = a + b;
    res      = total[bcz_pkg::ACC_WIDTH-1:bcz_pkg::RND_SHIFT];
    top_bits = res[RES_WIDTH-1:bcz_pkg::COORD_WIDTH-1];
    if ((&top_bits) || !(|top_bits)) begin
      r.value = res[bcz_pkg::COORD_WIDTH-1:0];
      r.sat   = 1'b0;
    end else begin
      r.value = res[RES_WIDTH-1] ? bcz_pkg::COORD_MIN : bcz_pkg::COORD_MAX;
      r.sat   = 1'b1;
    end
    return r;
  endfunction

  sat_res_t           res_x;
  sat_res_t           res_y;
  bcz_pkg::out_item_t out_nxt;
  bcz_pkg::out_item_t out6_r;

  assign res_x = round_sat(sums_x.sum_a, sums_x.sum_b);
  assign res_y = round_sat(sums_y.sum_a, sums_y.sum_b);

  assign out_nxt.out_x    = res_x.value;
  assign out_nxt.out_y    = res_y.value;
  assign out_nxt.overflow = res_x.sat | res_y.sat;

  // The result register holds while the output is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      out6_r <= out_nxt;
    end
  end

  assign out_item = out6_r;

endmodule

@@ hw/rtl/cubic_bezier_point_and_tangent.sv @@
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   in_data: cmd, param_t
// out      out  out_valid / out_stall out_data: out_x, out_y, overflow
// cfg      in   cfg_we                cfg_index, cfg_data (control points P0..P3)
//
// Seven register stages; one transaction can enter every cycle through the multiply-add
// pipeline while in_stall is low.
// Reset is synchronous and active low; it empties the pipeline and zeroes all control points.
// A stalled result holds in the output register while empty stages behind it keep
// filling; outside reset, the input stalls only when every stage holds a transaction.
//
// Top level of the cubic Bezier point and tangent evaluator.
// Depends on bcz_pkg, bcz_weights, bcz_mac, bcz_round and the assertion macro header.
`include "cubic_bezier_point_and_tangent_assert.svh"

module cubic_bezier_point_and_tangent (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bcz_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bcz_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [bcz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  bcz_pkg::coord_t                 cfg_data
);

  localparam int LAST = bcz_pkg::NUM_STAGES - 1;

  // Control point registers.
  bcz_pkg::coord_t cfg_regs_r [bcz_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < bcz_pkg::NUM_REGS; r++) begin
        cfg_regs_r[r] <= '0;
      end
    end else if (cfg_we) begin
      cfg_regs_r[cfg_index] <= cfg_data;
    end
  end

  bcz_pkg::coord_vec_t q_x;
  bcz_pkg::coord_vec_t q_y;

  assign q_x[0] = cfg_regs_r[bcz_pkg::REG_P0_X];
  assign q_x[1] = cfg_regs_r[bcz_pkg::REG_P1_X];
  assign q_x[2] = cfg_regs_r[bcz_pkg::REG_P2_X];
  assign q_x[3] = cfg_regs_r[bcz_pkg::REG_P3_X];
  assign q_y[0] = cfg_regs_r[bcz_pkg::REG_P0_Y];
  assign q_y[1] = cfg_regs_r[bcz_pkg::REG_P1_Y];
  assign q_y[2] = cfg_regs_r[bcz_pkg::REG_P2_Y];
  assign q_y[3] = cfg_regs_r[bcz_pkg::REG_P3_Y];

  // Stage valid bits; a stage advances when it is empty or the one after it advances.
  bcz_pkg::stage_vec_t valid_r;
  bcz_pkg::stage_vec_t valid_nxt;
  bcz_pkg::stage_vec_t stage_en;

  assign stage_en[LAST]  = !valid_r[LAST] || !out_stall;
  assign valid_nxt[0]    = stage_en[0] ? in_valid : valid_r[0];

  for (genvar k = 0; k < LAST; k++) begin : g_ctrl
    assign stage_en[k]    = !valid_r[k] || stage_en[k+1];
    assign valid_nxt[k+1] = stage_en[k+1] ? valid_r[k] : valid_r[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !rst_n || !stage_en[0];
  assign out_valid = valid_r[LAST];

  // Datapath.
  bcz_pkg::weight_vec_t weights;
  bcz_pkg::pair_sum_t   sums_x;
  bcz_pkg::pair_sum_t   sums_y;

  bcz_weights u_weights (
    .clk     (clk),
    .en      (stage_en[2:0]),
    .in_item (in_data),
    .w_out   (weights)
  );

  bcz_mac u_mac_x (
    .clk  (clk),
    .en   (stage_en[5:3]),
    .w_in (weights),
    .q_in (q_x),
    .sums (sums_x)
  );

  bcz_mac u_mac_y (
    .clk  (clk),
    .en   (stage_en[5:3]),
    .w_in (weights),
    .q_in (q_y),
    .sums (sums_y)
  );

  bcz_round u_round (
    .clk      (clk),
    .en       (stage_en[LAST]),
    .sums_x   (sums_x),
    .sums_y   (sums_y),
    .out_item (out_data)
  );

  // The input may only stall once every stage holds a transaction.
  `BCZ_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, in_stall, (&valid_r), "input stalled with an empty stage")

  // Transactions in flight change only by what enters and leaves.
  `BCZ_ASSERT_NEXT(a_inflight_count, clk, rst_n, 1'b1, $countones(valid_r) == $countones($past(valid_r)) + $past(in_valid && !in_stall) - $past(out_valid && !out_stall), "transaction lost or repeated in the pipeline")

  // A saturated result always sits at one of the coordinate bounds.
  `BCZ_ASSERT_IMPL(a_overflow_at_bound, clk, rst_n, out_valid && out_data.overflow, (out_data.out_x == bcz_pkg::COORD_MAX) || (out_data.out_x == bcz_pkg::COORD_MIN) || (out_data.out_y == bcz_pkg::COORD_MAX) || (out_data.out_y == bcz_pkg::COORD_MIN), "overflow flagged without a clamped coordinate")

endmodule
